[design/palette_greyscale_remap_top_defines.svh]
// ----------------------------------------------------------------------------
// palette_greyscale_remap_top_defines.svh
// Assertion macros shared by the palette grey remap design files.
// ----------------------------------------------------------------------------
`ifndef PALETTE_GREYSCALE_REMAP_TOP_DEFINES_SVH
`define PALETTE_GREYSCALE_REMAP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgr assertion failed");
// next-cycle implication
`define PGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgr assertion failed");
`else
`define PGR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/pgr_pkg.sv]
// ----------------------------------------------------------------------------
// pgr_pkg
// Types and constants of the palette grey remap block.
// ----------------------------------------------------------------------------
package pgr_pkg;

    localparam int MAX_ENTRIES_DEF = 256;

    localparam logic [8:0] SIZE_RESET = 9'd256;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result index when no grey entry exists
    localparam logic [7:0] NONE_IDX = 8'd255;

    // distance start value, above any 8-bit distance
    localparam logic [8:0] DIST_INIT = 9'd256;

    // x / 10 == (x * 6554) >> 16 for x <= 2550
    localparam logic [12:0] RECIP_10    = 13'd6554;
    localparam int          RECIP_SHIFT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SUM,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic       clear;
        logic       valid;
        logic [7:0] idx;
    } t_track_ctl;

endpackage

[design/pgr_best_track.sv]
// ----------------------------------------------------------------------------
// pgr_best_track
// Distance/compare unit: keeps the nearest grey candidate so far.
// ----------------------------------------------------------------------------
`include "palette_greyscale_remap_top_defines.svh"

module pgr_best_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pgr_pkg::t_track_ctl i_ctl,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_grey,
    output logic [7:0]         o_best_idx,
    output logic               o_found
);

    logic [7:0] gap;
    logic       better;
    logic [8:0] r_dist;
    logic [7:0] r_best_idx;
    logic       r_found;

    assign gap    = (i_red > i_grey) ? (i_red - i_grey) : (i_grey - i_red);
    // strict compare keeps the first (lowest) index on a tie
    assign better = i_ctl.valid && ({1'b0, gap} < r_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_dist     <= pgr_pkg::DIST_INIT;
            r_best_idx <= pgr_pkg::NONE_IDX;
        end else if (better) begin
            r_dist     <= {1'b0, gap};
            r_best_idx <= i_ctl.idx;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_found    = r_found;

    `PGR_ASSERT_NEXT(a_clear_drops_found, i_clk, i_rst_n, i_ctl.clear, !r_found)
    `PGR_ASSERT_NOW(a_found_has_index, i_clk, i_rst_n, r_found, r_best_idx != pgr_pkg::NONE_IDX)
    `PGR_ASSERT_NOW(a_found_from_hit, i_clk, i_rst_n, $rose(r_found), $past(i_ctl.valid))

endmodule

[design/palette_greyscale_remap_top.sv]
// ----------------------------------------------------------------------------
// palette_greyscale_remap_top
// Palette store with nearest-grey remap query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready): one transfer is a load
//   (i_req_type 0: write r,g,b at i_entry_index, mark it grey when r==g==b)
//   or a query (i_req_type 1: find the grey entry nearest to the queried
//   entry's luma). Loads give no result; each query gives one result on
//   the output channel (o_out_valid/i_out_ready).
//   Config channel (i_cfg_valid/o_cfg_ready, always ready) writes the
//   palette size; write it only while the block is idle.
// Sequence:
//   load: written to the palette RAM; next item taken the cycle after.
//   edge query (index 0 or >= size-1): goes from IDLE straight to RESULT.
//   scan query: passes FETCH, SUM, DIV, SCAN, DRAIN and RESULT; the single
//   read port of the palette RAM visits entries 1..size-2 one per cycle.
//   A new item is taken once the previous query has left the sequencer.
// Reset: sequencer idle, all grey marks cleared, size = 256. The palette
//   RAM is not cleared; querying an unwritten entry gives undefined data.
// Stall: the result sits in an output register; the sequencer accepts the
//   next item meanwhile, and a second result waits in RESULT until the
//   output register is free.
// ----------------------------------------------------------------------------
`include "palette_greyscale_remap_top_defines.svh"

module palette_greyscale_remap_top #(
    parameter int MAX_ENTRIES = pgr_pkg::MAX_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_remap_index,
    output logic       o_none_found,
    // config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    // ---------------- state ----------------
    pgr_pkg::t_state r_state, n_state;

    logic [8:0]       r_palette_size;
    logic [7:0]       r_query_idx;
    logic             r_edge;
    logic [11:0]      r_sum;
    logic [7:0]       r_grey;
    logic [IDX_W-1:0] r_scan_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;

    logic             r_out_valid;
    logic [7:0]       r_out_idx;
    logic             r_out_none;

    // palette RAM (r,g,b) and grey marks
    logic [23:0]            r_palette [MAX_ENTRIES];
    logic [23:0]            r_rd_data;
    logic [MAX_ENTRIES-1:0] r_grey_marks;

    // ---------------- combinational ----------------
    logic             in_xfer;
    logic             load_xfer;
    logic             query_xfer;
    logic             load_in_range;
    logic [8:0]       size_use;
    logic             edge_query;
    logic [IDX_W-1:0] scan_last;
    logic [IDX_W-1:0] rd_addr;
    logic             out_free;
    logic             res_load;
    logic             clr_track;
    logic [11:0]      sum_next;
    logic [24:0]      grey_prod;
    logic [7:0]       best_idx;
    logic             found;
    pgr_pkg::t_track_ctl track_ctl;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign load_xfer  = in_xfer && (i_req_type == pgr_pkg::REQ_LOAD);
    assign query_xfer = in_xfer && (i_req_type == pgr_pkg::REQ_QUERY);

    assign load_in_range = ({1'b0, i_entry_index} < 9'(MAX_ENTRIES));

    // size capped at the store depth
    assign size_use = (r_palette_size > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : r_palette_size;

    assign edge_query = (i_entry_index == 8'd0) || (({1'b0, i_entry_index} + 9'd1) >= size_use);

    // last scanned entry is size-2; only used once size >= 3
    assign scan_last = IDX_W'(size_use - 9'd2);

    assign out_free = !r_out_valid || i_out_ready;

    // 2r + 7g + b from the fetched entry
    assign sum_next = (12'(r_rd_data[23:16]) << 1) + (12'(r_rd_data[15:8]) << 3)
                    - 12'(r_rd_data[15:8]) + 12'(r_rd_data[7:0]);

    // divide by 10 via reciprocal multiply
    assign grey_prod = 25'(r_sum) * 25'(pgr_pkg::RECIP_10);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pgr_pkg::ST_IDLE: begin
                if (query_xfer) begin
                    n_state = edge_query ? pgr_pkg::ST_RESULT : pgr_pkg::ST_FETCH;
                end
            end
            pgr_pkg::ST_FETCH: n_state = pgr_pkg::ST_SUM;
            pgr_pkg::ST_SUM:   n_state = pgr_pkg::ST_DIV;
            pgr_pkg::ST_DIV:   n_state = pgr_pkg::ST_SCAN;
            pgr_pkg::ST_SCAN: begin
                if (r_scan_idx == scan_last) begin
                    n_state = pgr_pkg::ST_DRAIN;
                end
            end
            pgr_pkg::ST_DRAIN: n_state = pgr_pkg::ST_RESULT;
            pgr_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = pgr_pkg::ST_IDLE;
                end
            end
            default: n_state = pgr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        rd_addr    = r_scan_idx;
        clr_track  = 1'b0;
        res_load   = 1'b0;
        unique case (r_state)
            pgr_pkg::ST_IDLE:   o_in_ready = 1'b1;
            pgr_pkg::ST_FETCH:  rd_addr = r_query_idx[IDX_W-1:0];
            pgr_pkg::ST_DIV:    clr_track = 1'b1;
            pgr_pkg::ST_RESULT: res_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- config register ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= pgr_pkg::SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_palette_size <= i_cfg_data;
        end
    end

    // ---------------- palette RAM ----------------
    always_ff @(posedge i_clk) begin
        if (load_xfer && load_in_range) begin
            r_palette[i_entry_index[IDX_W-1:0]] <= {i_red, i_green, i_blue};
        end
        r_rd_data <= r_palette[rd_addr];
    end

    // grey marks: set/cleared on every in-range load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grey_marks <= '0;
        end else if (load_xfer && load_in_range) begin
            r_grey_marks[i_entry_index[IDX_W-1:0]] <=
                (i_red == i_green) && (i_green == i_blue);
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (query_xfer) begin
            r_query_idx <= i_entry_index;
            r_edge      <= edge_query;
        end
        if (r_state == pgr_pkg::ST_SUM) begin
            r_sum <= sum_next;
        end
        if (r_state == pgr_pkg::ST_DIV) begin
            r_grey <= 8'(grey_prod >> pgr_pkg::RECIP_SHIFT);
        end
        // scan address counter and compare tag, registered to match the RAM read delay
        if (r_state == pgr_pkg::ST_DIV) begin
            r_scan_idx <= IDX_W'(1);
        end else if (r_state == pgr_pkg::ST_SCAN) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        r_cmp_idx <= r_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == pgr_pkg::ST_SCAN) && r_grey_marks[r_scan_idx];
        end
    end

    assign track_ctl.clear = clr_track;
    assign track_ctl.valid = r_cmp_vld;
    assign track_ctl.idx   = 8'(r_cmp_idx);

    pgr_best_track u_best_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (track_ctl),
        .i_red      (r_rd_data[23:16]),
        .i_grey     (r_grey),
        .o_best_idx (best_idx),
        .o_found    (found)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_idx  <= r_edge ? r_query_idx : best_idx;
            r_out_none <= r_edge ? 1'b0 : !found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_remap_index = r_out_idx;
    assign o_none_found  = r_out_none;

    // ---------------- checks ----------------
    `PGR_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, r_state == pgr_pkg::ST_SCAN, (r_scan_idx != '0) && (r_scan_idx <= scan_last))
    `PGR_ASSERT_NEXT(a_query_leaves_idle, i_clk, i_rst_n, query_xfer, r_state != pgr_pkg::ST_IDLE)
    `PGR_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, res_load, o_out_valid)

endmodule

[tb/sv/palette_greyscale_remap_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_greyscale_remap_top_test
// Self-checking bench for the palette grey remap block. A clocked driver
// takes load and query requests from a backlog queue and sends them over the
// input channel. Each accepted query is predicted against a local copy of the
// palette, grey marks and size. A clocked monitor compares every result
// transfer, field by field, with the oldest prediction. Stimulus is a short
// directed list followed by randomized phases at several palette sizes.
// ----------------------------------------------------------------------------
module palette_greyscale_remap_top_test;

    typedef struct packed {
        logic       req_type;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pal_req;

    typedef struct packed {
        logic [7:0] remap_index;
        logic       none_found;
    } t_remap;

    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;     // wait after the queues empty, for a trailing load
    localparam int TAIL_CYCLES  = 300;   // longer than one full-size scan
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_PHASES   = 9;

    // size per random phase; -1 picks a random small size
    localparam int PHASE_SIZE [NUM_PHASES]  = '{3, 2, 4, -1, 511, 16, -1, 256, 8};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{60, 40, 80, 150, 60, 150, 150, 60, 150};

    // ------------------------------------------------------------------------
    // Clock, reset and DUT-facing signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic       req_type    = pgr_pkg::REQ_LOAD;
    logic [7:0] entry_index = 8'd0;
    logic [7:0] red         = 8'd0;
    logic [7:0] green       = 8'd0;
    logic [7:0] blue        = 8'd0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] remap_index;
    logic       none_found;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [8:0] cfg_data    = 9'd0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    palette_greyscale_remap_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (req_type),
        .i_entry_index (entry_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_remap_index (remap_index),
        .o_none_found  (none_found),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Local copy of the block's state, updated on accepted transfers only.
    // ------------------------------------------------------------------------
    bit   [7:0] pal_red   [256];
    bit   [7:0] pal_green [256];
    bit   [7:0] pal_blue  [256];
    bit         grey_mark [256];
    logic [8:0] size_reg = pgr_pkg::SIZE_RESET;

    t_pal_req req_backlog [$];   // requests waiting for the driver
    t_remap   remaps_due  [$];   // predicted results, oldest first
    t_pal_req drive_req;
    t_remap   oldest_due;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq      = 0;       // bumped to ask the monitor for a hold-off
    int hold_seen     = 0;
    int hold_left     = 0;
    int error_count   = 0;

    // Generation-side view: which entries have been loaded, and the size in use.
    // A scan query must only name a loaded entry.
    bit          loaded_map [256];
    int unsigned loaded_list [$];
    int          gen_used = pgr_pkg::MAX_ENTRIES_DEF;

    // Nearest-grey lookup for one query against the current local state.
    function automatic t_remap nearest_grey(input logic [7:0] idx);
        t_remap      res;
        int          used;
        int unsigned luma;
        int unsigned gap;
        int unsigned best_gap;
        used = (int'(size_reg) > pgr_pkg::MAX_ENTRIES_DEF) ? pgr_pkg::MAX_ENTRIES_DEF
                                                           : int'(size_reg);
        res.remap_index = idx;
        res.none_found  = 1'b0;
        // index 0 and anything at or past the last entry map to themselves
        if (idx == 8'd0 || int'(idx) + 1 >= used)
            return res;
        luma = (2 * pal_red[idx] + 7 * pal_green[idx] + pal_blue[idx]) / 10;
        res.remap_index = pgr_pkg::NONE_IDX;
        res.none_found  = 1'b1;
        best_gap = 32'h7fff_ffff;
        for (int i = 1; i + 1 < used; i++) begin
            if (grey_mark[i]) begin
                gap = (pal_red[i] > luma) ? pal_red[i] - luma : luma - pal_red[i];
                // strict compare: ties keep the lowest index
                if (gap < best_gap) begin
                    best_gap        = gap;
                    res.remap_index = 8'(i);
                    res.none_found  = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // Apply one accepted request: loads update the palette, queries predict.
    task automatic apply_req(input t_pal_req req);
        if (req.req_type == pgr_pkg::REQ_LOAD) begin
            pal_red[req.entry_index]   = req.red;
            pal_green[req.entry_index] = req.green;
            pal_blue[req.entry_index]  = req.blue;
            grey_mark[req.entry_index] = (req.red == req.green) && (req.green == req.blue);
        end else begin
            remaps_due.push_back(nearest_grey(req.entry_index));
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers backlog items on the input channel. Valid only drops
    // after a transfer, and the payload holds until the transfer.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                apply_req(drive_req);
            if (!in_valid || in_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_req = req_backlog.pop_front();
                    in_valid    <= 1'b1;
                    req_type    <= drive_req.req_type;
                    entry_index <= drive_req.entry_index;
                    red         <= drive_req.red;
                    green       <= drive_req.green;
                    blue        <= drive_req.blue;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result transfer and drives the output ready,
    // either randomly or held low for a long counted stretch on request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (remaps_due.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: result with none pending: remap_index=%0d none_found=%0b",
                                 $realtime, remap_index, none_found);
                end else begin
                    oldest_due = remaps_due.pop_front();
                    if (remap_index !== oldest_due.remap_index ||
                        none_found !== oldest_due.none_found) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: remap mismatch: remap_index exp %0d got %0d, %s",
                                     $realtime, oldest_due.remap_index, remap_index,
                                     $sformatf("none_found exp %0b got %0b",
                                               oldest_due.none_found, none_found));
                    end
                end
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_seen != hold_seq) begin
                hold_seen <= hold_seq;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_req(input logic kind, input logic [7:0] idx,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pal_req req;
        req = '{req_type: kind, entry_index: idx, red: r, green: g, blue: b};
        if (kind == pgr_pkg::REQ_LOAD && !loaded_map[idx]) begin
            loaded_map[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        req_backlog.push_back(req);
    endtask

    // Mostly scan queries on loaded entries, the rest edge and out-of-range ones.
    function automatic logic [7:0] pick_query_index();
        int unsigned cand;
        int unsigned lower;
        if ($urandom_range(99) < 80 && loaded_list.size() != 0) begin
            for (int t = 0; t < 16; t++) begin
                cand = loaded_list[$urandom_range(loaded_list.size() - 1)];
                if (cand >= 1 && int'(cand) + 2 <= gen_used)
                    return 8'(cand);
            end
        end
        lower = (gen_used >= 1) ? gen_used - 1 : 0;
        case ($urandom_range(2))
            0:       return 8'd0;
            1:       return 8'(lower);
            default: return 8'($urandom_range(255, lower));
        endcase
    endfunction

    task automatic queue_random_req();
        logic [7:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         pick;
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        if ($urandom_range(99) < 35) begin
            // loads mostly land inside the size in use
            if (gen_used > 0 && $urandom_range(99) < 75)
                idx = 8'($urandom_range(gen_used - 1));
            else
                idx = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 45) begin
                // grey entry, sometimes at black or white
                r = ($urandom_range(9) == 0) ? ($urandom_range(1) != 0 ? 8'hff : 8'h00) : r;
                g = r;
                b = r;
            end else if (pick < 55) begin
                // off by one bit in one channel: must clear the mark
                g = r;
                b = r;
                case ($urandom_range(2))
                    0:       r = r ^ 8'h01;
                    1:       g = g ^ 8'h01;
                    default: b = b ^ 8'h01;
                endcase
            end
            queue_req(pgr_pkg::REQ_LOAD, idx, r, g, b);
        end else begin
            queue_req(pgr_pkg::REQ_QUERY, pick_query_index(), r, g, b);
        end
    endtask

    task automatic write_palette_size(input logic [8:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        size_reg = value;
        gen_used = (int'(value) > pgr_pkg::MAX_ENTRIES_DEF) ? pgr_pkg::MAX_ENTRIES_DEF
                                                            : int'(value);
        cfg_valid <= 1'b0;
    endtask

    // Sample at the falling edge so the driver's pops and pushes have settled.
    task automatic wait_settled();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || in_valid || remaps_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int size_now;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 16;
        recv_idle_pct <= 46;
        @(negedge i_clk);

        // Directed part at the reset size of 256.
        queue_req(pgr_pkg::REQ_QUERY, 8'd0,   8'hff, 8'h00, 8'h5a);   // entry 0 maps to itself
        queue_req(pgr_pkg::REQ_QUERY, 8'd255, 8'h00, 8'hff, 8'ha5);   // last entry maps to itself
        queue_req(pgr_pkg::REQ_LOAD,  8'd5,   8'hff, 8'h00, 8'hff);   // not grey
        queue_req(pgr_pkg::REQ_QUERY, 8'd5,   8'h00, 8'h00, 8'h00);   // no grey entry at all
        queue_req(pgr_pkg::REQ_LOAD,  8'd0,   8'd128, 8'd128, 8'd128); // marked, never scanned
        queue_req(pgr_pkg::REQ_LOAD,  8'd255, 8'd200, 8'd200, 8'd200); // marked, never scanned
        queue_req(pgr_pkg::REQ_QUERY, 8'd5,   8'hff, 8'hff, 8'hff);   // still none found
        queue_req(pgr_pkg::REQ_LOAD,  8'd1,   8'd0,   8'd0,   8'd0);
        queue_req(pgr_pkg::REQ_LOAD,  8'd254, 8'd255, 8'd255, 8'd255);
        queue_req(pgr_pkg::REQ_LOAD,  8'd100, 8'd100, 8'd100, 8'd100);
        queue_req(pgr_pkg::REQ_LOAD,  8'd101, 8'd100, 8'd100, 8'd100); // tie with 100
        queue_req(pgr_pkg::REQ_QUERY, 8'd5,   8'h00, 8'h00, 8'h00);   // luma 76: tie goes to 100
        queue_req(pgr_pkg::REQ_LOAD,  8'd7,   8'd255, 8'd255, 8'd254);
        queue_req(pgr_pkg::REQ_QUERY, 8'd7,   8'h00, 8'h00, 8'h00);   // luma 254: picks 254
        queue_req(pgr_pkg::REQ_QUERY, 8'd1,   8'h00, 8'h00, 8'h00);   // black finds itself
        queue_req(pgr_pkg::REQ_QUERY, 8'd254, 8'h00, 8'h00, 8'h00);   // last scannable entry
        queue_req(pgr_pkg::REQ_LOAD,  8'd100, 8'd100, 8'd100, 8'd99); // reload clears the mark
        queue_req(pgr_pkg::REQ_QUERY, 8'd5,   8'h00, 8'h00, 8'h00);   // now 101 wins
        queue_req(pgr_pkg::REQ_LOAD,  8'd3,   8'd0,   8'd255, 8'd0);
        queue_req(pgr_pkg::REQ_QUERY, 8'd3,   8'hff, 8'hff, 8'hff);   // green-heavy luma 178
        queue_req(pgr_pkg::REQ_QUERY, 8'd100, 8'h00, 8'h00, 8'h00);
        wait_settled();

        // Randomized phases. Idle mix: first sender 16 / receiver 46,
        // then swapped, then no idling at all.
        for (int p = 0; p < NUM_PHASES; p++) begin
            size_now = (PHASE_SIZE[p] < 0) ? $urandom_range(64, 5) : PHASE_SIZE[p];
            write_palette_size(9'(size_now));
            @(negedge i_clk);
            if (p == 3) begin
                send_idle_pct <= 46;
                recv_idle_pct <= 16;
            end else if (p == 6) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            // long output stall while the sender keeps offering items
            if (p == 5)
                hold_seq <= hold_seq + 1;
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
                queue_random_req();
            // the sender pauses here until every result has come back
            wait_settled();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && remaps_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard limit, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
